// ===== src/rsw_pkg.sv =====
// Shared types for the binary radix word sorter.
package rsw_pkg;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_FINDTOP,
		ST_POP,
		ST_READ,
		ST_EVAL,
		ST_SWAP,
		ST_PUSH,
		ST_OUT_RD,
		ST_OUT_LD
	} state_t;

	typedef struct packed {
		logic we;
		logic re_a;
		logic re_b;
	} ram_ctrl_t;

	typedef struct packed {
		logic pop;
		logic push_ones;
		logic push_zeros;
	} stk_ctrl_t;

endpackage

// ===== src/rsw_word_ram.sv =====
// Word store: one write port, two registered read ports.
module rsw_word_ram #(
	parameter int DEPTH = 64,
	parameter int AW = 6,
	parameter int DW = 32
) (
	input  logic                clk,
	input  rsw_pkg::ram_ctrl_t  ctrl,
	input  logic [AW-1:0]       waddr,
	input  logic [DW-1:0]       wdata,
	input  logic [AW-1:0]       raddr_a,
	input  logic [AW-1:0]       raddr_b,
	output logic [DW-1:0]       rdata_a,
	output logic [DW-1:0]       rdata_b
);
	import rsw_pkg::*;

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rd_a_q;
	logic [DW-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (ctrl.we) begin
			mem_q[waddr] <= wdata;
		end
		if (ctrl.re_a) begin
			rd_a_q <= mem_q[raddr_a];
		end
		if (ctrl.re_b) begin
			rd_b_q <= mem_q[raddr_b];
		end
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;

endmodule

// ===== src/rsw_part_stack.sv =====
// Stack of pending partitions: pops one, pushes up to two per cycle.
module rsw_part_stack #(
	parameter int DEPTH = 32,
	parameter int EW = 18
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rsw_pkg::stk_ctrl_t  ctrl,
	input  logic [EW-1:0]       ones_entry,
	input  logic [EW-1:0]       zeros_entry,
	output logic [EW-1:0]       top_entry,
	output logic                empty
);
	import rsw_pkg::*;

	localparam int SPW = $clog2(DEPTH + 1);
	localparam int SIW = $clog2(DEPTH);

	logic [EW-1:0]  mem_q [DEPTH];
	logic [SPW-1:0] sp_q;
	logic           ones_ok;
	logic           zeros_ok;
	logic [SPW:0]   sp_after_ones;
	logic [SPW-1:0] zeros_slot;
	logic [SPW-1:0] top_slot;

	// pushes past the top are dropped, as a full stack would
	assign ones_ok       = ctrl.push_ones && (sp_q < SPW'(DEPTH));
	assign sp_after_ones = {1'b0, sp_q} + (SPW + 1)'(ones_ok);
	assign zeros_ok      = ctrl.push_zeros && (sp_after_ones < (SPW + 1)'(DEPTH));
	assign zeros_slot    = sp_after_ones[SPW-1:0];
	assign top_slot      = sp_q - SPW'(1);

	assign top_entry = mem_q[top_slot[SIW-1:0]];
	assign empty     = (sp_q == '0);

	always_ff @(posedge clk) begin
		if (ones_ok) begin
			mem_q[sp_q[SIW-1:0]] <= ones_entry;
		end
		if (zeros_ok) begin
			mem_q[zeros_slot[SIW-1:0]] <= zeros_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else begin
			sp_q <= sp_q - SPW'(ctrl.pop) + SPW'(ones_ok) + SPW'(zeros_ok);
		end
	end

endmodule

// ===== src/binary_radix_sort_words_unit.sv =====
// Top level: load, MSD binary radix sort and readout of a set of words.
//
// Input stream: one word per transfer on s_axis_*, s_axis_tlast marks the last
// word of a set. Up to MAX_WORDS words are stored; further words are dropped
// and every result of that set carries words_dropped in m_axis_tuser.
// Output stream: the stored words in ascending order on m_axis_*, tlast on the
// last one. A set of one word is passed straight to readout.
// Timing: loading takes one word per cycle while s_axis_tvalid is high. After
// the last word, the top set bit of the largest word is searched one bit a
// cycle. Each partition pass pops an entry, reads and tests each word, swaps
// each word with the tested bit clear down to the zeros boundary and pushes
// the halves left to sort, all through the one shared word-store port pair
// and bit tester. Up to WORD_BITS levels of passes run; worst is a full set of
// equal words with only the top bit set. Readout reads each word, then loads it.
// s_axis_tready is high only while loading; the next set starts loading as
// soon as the last result sits in the output register.
// Reset clears the word count, drop flag, running maximum, partition stack
// pointer and output valid; stored words need no clearing.
// A stalled receiver holds the output register and the readout simply waits.
module binary_radix_sort_words_unit #(
	parameter int MAX_WORDS = 64,
	parameter int WORD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] word
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] sorted_word
	output logic        m_axis_tlast,
	output logic [0:0]  m_axis_tuser    // [0] words_dropped
);
	import rsw_pkg::*;

	localparam int SW  = (WORD_BITS < 32) ? WORD_BITS : 32;
	localparam int AW  = $clog2(MAX_WORDS);
	localparam int CW  = $clog2(MAX_WORDS + 1);
	localparam int BW  = $clog2(SW);
	localparam int EW  = AW + CW + BW;

	state_t state_q, state_d;

	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic [SW-1:0] max_q;
	logic [BW-1:0] bp_q;
	logic [AW-1:0] lo_q;
	logic [CW-1:0] len_q;
	logic [BW-1:0] bit_q;
	logic [CW-1:0] j_q;
	logic [CW-1:0] zeros_q;
	logic [CW-1:0] k_q;
	logic          m_valid_q;
	logic [31:0]   m_data_q;
	logic          m_last_q;
	logic          m_user_q;

	ram_ctrl_t     ram_ctrl;
	logic [AW-1:0] waddr;
	logic [SW-1:0] wdata;
	logic [AW-1:0] raddr_a;
	logic [AW-1:0] raddr_b;
	logic [SW-1:0] rd_a;
	logic [SW-1:0] rd_b;

	stk_ctrl_t     stk_ctrl;
	logic [EW-1:0] ones_entry;
	logic [EW-1:0] zeros_entry;
	logic [EW-1:0] top_entry;
	logic          stk_empty;

	logic          in_xfer;
	logic          out_xfer;
	logic          out_free;
	logic [SW-1:0] in_word;
	logic          has_room;
	logic [CW-1:0] count_after;
	logic          find_hit;
	logic [AW-1:0] addr_a;
	logic [AW-1:0] addr_z;
	logic [CW-1:0] ones_len;
	logic          probe_set;
	logic          last_out;

	assign in_word     = s_axis_tdata[SW-1:0];
	assign in_xfer     = s_axis_tvalid && s_axis_tready;
	assign out_xfer    = m_valid_q && m_axis_tready;
	assign out_free    = !m_valid_q || m_axis_tready;
	assign has_room    = (count_q < CW'(MAX_WORDS));
	assign count_after = count_q + CW'(has_room);
	assign find_hit    = max_q[bp_q] || (bp_q == '0);
	assign addr_a      = lo_q + j_q[AW-1:0];
	assign addr_z      = lo_q + zeros_q[AW-1:0];
	assign ones_len    = len_q - zeros_q;
	assign probe_set   = rd_a[bit_q];
	assign last_out    = (k_q == count_q - CW'(1));

	rsw_word_ram #(
		.DEPTH (MAX_WORDS),
		.AW    (AW),
		.DW    (SW)
	) u_ram (
		.clk     (clk),
		.ctrl    (ram_ctrl),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	rsw_part_stack #(
		.DEPTH (SW),
		.EW    (EW)
	) u_stack (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (stk_ctrl),
		.ones_entry  (ones_entry),
		.zeros_entry (zeros_entry),
		.top_entry   (top_entry),
		.empty       (stk_empty)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (in_xfer && s_axis_tlast) begin
					state_d = (count_after < CW'(2)) ? ST_OUT_RD : ST_FINDTOP;
				end
			end
			ST_FINDTOP: begin
				if (find_hit) begin
					state_d = ST_POP;
				end
			end
			ST_POP:     state_d = stk_empty ? ST_OUT_RD : ST_READ;
			ST_READ:    state_d = (j_q == len_q) ? ST_PUSH : ST_EVAL;
			ST_EVAL:    state_d = probe_set ? ST_READ : ST_SWAP;
			ST_SWAP:    state_d = ST_READ;
			ST_PUSH:    state_d = ST_POP;
			ST_OUT_RD: begin
				if (out_free) begin
					state_d = ST_OUT_LD;
				end
			end
			ST_OUT_LD:  state_d = last_out ? ST_LOAD : ST_OUT_RD;
			default:    state_d = ST_LOAD;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_axis_tready = 1'b0;
		ram_ctrl      = '0;
		waddr         = addr_a;
		wdata         = rd_b;
		raddr_a       = addr_a;
		raddr_b       = addr_z;
		stk_ctrl      = '0;
		ones_entry    = {addr_z, ones_len, bit_q - BW'(1)};
		zeros_entry   = {lo_q, zeros_q, bit_q - BW'(1)};
		case (state_q)
			ST_LOAD: begin
				s_axis_tready = 1'b1;
				ram_ctrl.we   = in_xfer && has_room;
				waddr         = count_q[AW-1:0];
				wdata         = in_word;
			end
			ST_FINDTOP: begin
				// seed partition: whole set at the top set bit
				stk_ctrl.push_ones = find_hit;
				ones_entry         = {AW'(0), count_q, bp_q};
			end
			ST_POP: begin
				stk_ctrl.pop = !stk_empty;
			end
			ST_READ: begin
				ram_ctrl.re_a = (j_q != len_q);
				ram_ctrl.re_b = (j_q != len_q);
			end
			ST_EVAL: begin
				// zero at probe bit: write the zeros-boundary word into its slot, ST_SWAP then moves it down
				ram_ctrl.we = !probe_set;
				waddr       = addr_a;
				wdata       = rd_b;
			end
			ST_SWAP: begin
				ram_ctrl.we = 1'b1;
				waddr       = addr_z;
				wdata       = rd_a;
			end
			ST_PUSH: begin
				stk_ctrl.push_ones  = (bit_q != '0) && (ones_len >= CW'(2));
				stk_ctrl.push_zeros = (bit_q != '0) && (zeros_q >= CW'(2));
			end
			ST_OUT_RD: begin
				ram_ctrl.re_a = out_free;
				raddr_a       = k_q[AW-1:0];
			end
			ST_OUT_LD: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			ovf_q   <= 1'b0;
			max_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_LOAD: begin
					if (in_xfer) begin
						count_q <= count_after;
						if (!has_room) begin
							ovf_q <= 1'b1;
						end else if (in_word > max_q) begin
							max_q <= in_word;
						end
					end
				end
				ST_OUT_LD: begin
					if (last_out) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
						max_q   <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// partition and readout counters
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				bp_q <= BW'(SW - 1);
				k_q  <= '0;
			end
			ST_FINDTOP: begin
				if (!find_hit) begin
					bp_q <= bp_q - BW'(1);
				end
			end
			ST_POP: begin
				{lo_q, len_q, bit_q} <= top_entry;
				j_q     <= '0;
				zeros_q <= '0;
			end
			ST_EVAL: begin
				if (probe_set) begin
					j_q <= j_q + CW'(1);
				end
			end
			ST_SWAP: begin
				j_q     <= j_q + CW'(1);
				zeros_q <= zeros_q + CW'(1);
			end
			ST_OUT_LD: begin
				k_q <= k_q + CW'(1);
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_OUT_LD) begin
			m_valid_q <= 1'b1;
		end else if (out_xfer) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT_LD) begin
			m_data_q <= 32'(rd_a);
			m_last_q <= last_out;
			m_user_q <= ovf_q;
		end
	end

	assign m_axis_tvalid   = m_valid_q;
	assign m_axis_tdata    = m_data_q;
	assign m_axis_tlast    = m_last_q;
	assign m_axis_tuser[0] = m_user_q;

endmodule

// ===== tb/sv/rsw_sort_checker.sv =====
// Checker for the radix word sorter: tracks both streams, predicts each sorted set, compares.
`timescale 1ns / 100ps

module rsw_sort_checker #(
	parameter int MAX_WORDS = 64,
	parameter int WORD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] word
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // [31:0] sorted_word
	input  logic        m_tlast,
	input  logic [0:0]  m_tuser,   // [0] words_dropped
	output int          errors,
	output int          pending
);

	localparam int STACK_DEPTH = WORD_BITS + 1;

	typedef struct packed {
		logic [31:0] word;
		logic        last;
		logic        dropped;
	} sorted_item_t;

	logic [31:0]  stash [MAX_WORDS];
	int unsigned  stash_n = 0;
	logic         stash_over = 1'b0;
	logic [31:0]  stash_max = '0;
	sorted_item_t sorted_q [$];

	initial begin
		errors = 0;
		pending = 0;
	end

	function automatic int unsigned top_set_bit(logic [31:0] v);
		for (int b = WORD_BITS - 1; b > 0; b--)
			if (v[b])
				return b;
		return 0;
	endfunction

	// in-place MSD partitioning by one bit per pass, ones half pushed first
	function automatic void partition_stash();
		int unsigned stk_lo [STACK_DEPTH];
		int unsigned stk_len [STACK_DEPTH];
		int unsigned stk_bit [STACK_DEPTH];
		int unsigned sp, zeros, a, z, p_lo, p_len, p_bit;
		logic [31:0] v;
		if (stash_n < 2)
			return;
		stk_lo[0] = 0;
		stk_len[0] = stash_n;
		stk_bit[0] = top_set_bit(stash_max);
		sp = 1;
		while (sp > 0) begin
			sp--;
			p_lo = stk_lo[sp];
			p_len = stk_len[sp];
			p_bit = stk_bit[sp];
			zeros = 0;
			for (int j = 0; j < p_len; j++) begin
				a = p_lo + j;
				v = stash[a];
				if (!v[p_bit]) begin
					z = p_lo + zeros;
					stash[a] = stash[z];
					stash[z] = v;
					zeros++;
				end
			end
			if (p_bit == 0)
				continue;
			if (p_len - zeros >= 2 && sp < STACK_DEPTH) begin
				stk_lo[sp] = p_lo + zeros;
				stk_len[sp] = p_len - zeros;
				stk_bit[sp] = p_bit - 1;
				sp++;
			end
			if (zeros >= 2 && sp < STACK_DEPTH) begin
				stk_lo[sp] = p_lo;
				stk_len[sp] = zeros;
				stk_bit[sp] = p_bit - 1;
				sp++;
			end
		end
	endfunction

	function automatic void report(string field, logic [31:0] want, logic [31:0] got);
		$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
		errors++;
	endfunction

	always @(posedge clk) begin
		sorted_item_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (sorted_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h last %b dropped %b",
						$time, m_tdata, m_tlast, m_tuser[0]);
					errors++;
				end else begin
					want = sorted_q.pop_front();
					if (m_tdata !== want.word)
						report("sorted_word", want.word, m_tdata);
					if (m_tlast !== want.last)
						report("end_of_run", 32'(want.last), 32'(m_tlast));
					if (m_tuser[0] !== want.dropped)
						report("words_dropped", 32'(want.dropped), 32'(m_tuser[0]));
				end
			end
			if (s_tvalid && s_tready) begin
				if (stash_n < MAX_WORDS) begin
					stash[stash_n] = s_tdata;
					stash_n++;
					if (s_tdata > stash_max)
						stash_max = s_tdata;
				end else begin
					stash_over = 1'b1;
				end
				if (s_tlast) begin
					partition_stash();
					for (int k = 0; k < stash_n; k++)
						sorted_q.push_back('{word: stash[k], last: (k + 1 == stash_n),
							dropped: stash_over});
					stash_n = 0;
					stash_over = 1'b0;
					stash_max = '0;
				end
			end
			pending = sorted_q.size();
		end
	end

endmodule

// ===== tb/sv/tb_binary_radix_sort_words_unit.sv =====
// Testbench top for the radix word sorter: clock, reset, stream stimulus and verdict.
`timescale 1ns / 100ps

module tb_binary_radix_sort_words_unit;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 600;
	localparam int SETTLE_CYCLES = 200;

	typedef enum int unsigned {
		FILL_RANDOM,
		FILL_NARROW,
		FILL_REPEAT,
		FILL_ZERO,
		FILL_EDGES
	} fill_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tlast;
	logic [0:0]  m_tuser;

	int          errors;
	int          pending;
	int unsigned snd_idle_pct = 0;
	int unsigned rcv_idle_pct = 0;
	int unsigned items_sent = 0;
	int unsigned cycles = 0;
	bit          hold_req = 1'b0;

	binary_radix_sort_words_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tlast  (s_tlast),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tlast  (m_tlast),
		.m_axis_tuser  (m_tuser)
	);

	rsw_sort_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.errors   (errors),
		.pending  (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// receiver: random backpressure, plus a long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			m_tready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	task automatic send_word(input logic [31:0] w, input logic last);
		bit took;
		while ($urandom_range(99) < snd_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= w;
		s_tlast <= last;
		// tready is stable between edges, so sample it mid-cycle
		do begin
			@(negedge clk);
			took = s_tready;
			@(posedge clk);
		end while (!took);
		items_sent++;
	endtask

	task automatic send_set(input int unsigned n, input fill_t fill);
		logic [31:0] pool [3];
		logic [31:0] w;
		for (int i = 0; i < 3; i++)
			pool[i] = $urandom >> $urandom_range(31);
		for (int unsigned k = 0; k < n; k++) begin
			w = $urandom;
			case (fill)
				FILL_NARROW: w = w >> $urandom_range(31);
				FILL_REPEAT: w = pool[$urandom_range(2)];
				FILL_ZERO:   w = '0;
				FILL_EDGES: begin
					case ($urandom_range(3))
						0: w = '0;
						1: w = '1;
						2: w = 32'd1 << $urandom_range(31);
						default: w = ~(32'd1 << $urandom_range(31));
					endcase
				end
				default: ;
			endcase
			send_word(w, k + 1 == n);
		end
	endtask

	// stop offering, so the last word is not taken again
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	task automatic random_sets(input int unsigned upto);
		int unsigned n;
		while (items_sent < upto) begin
			if ($urandom_range(15) == 0)
				n = $urandom_range(62, 67);
			else
				n = $urandom_range(1, 10);
			send_set(n, fill_t'($urandom_range(4)));
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		snd_idle_pct = 17;
		rcv_idle_pct = 56;

		// sets of one word at both extremes
		send_word(32'h0000_0000, 1'b1);
		send_word(32'hFFFF_FFFF, 1'b1);
		// all zero: only bit 0 gets tested
		send_word(32'h0000_0000, 1'b0);
		send_word(32'h0000_0000, 1'b0);
		send_word(32'h0000_0000, 1'b0);
		send_word(32'h0000_0000, 1'b1);
		// field extremes and single-bit neighbors
		send_word(32'hFFFF_FFFF, 1'b0);
		send_word(32'h0000_0000, 1'b0);
		send_word(32'h8000_0000, 1'b0);
		send_word(32'h7FFF_FFFF, 1'b0);
		send_word(32'h0000_0001, 1'b0);
		send_word(32'hFFFF_FFFF, 1'b1);
		// smallest set that sorts
		send_word(32'h0000_0005, 1'b0);
		send_word(32'h0000_0003, 1'b1);
		// duplicates with the top bit at zero
		send_word(32'h0000_0001, 1'b0);
		send_word(32'h0000_0000, 1'b0);
		send_word(32'h0000_0001, 1'b0);
		send_word(32'h0000_0000, 1'b0);
		send_word(32'h0000_0001, 1'b1);

		// full store, then overflow where the final word itself is dropped
		send_set(64, FILL_RANDOM);
		send_set(66, FILL_NARROW);
		random_sets(170);

		// receiver stalls long while the sender keeps offering
		wait_drained();
		snd_idle_pct = 56;
		rcv_idle_pct = 17;
		hold_req = 1'b1;
		random_sets(225);

		// sender pauses until everything is out
		wait_drained();
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		random_sets(280);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
